/* hw/rtl/upd_pkg.sv */
// shared types, character codes and hex digit decoding for the url percent decoder
package upd_pkg;

  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] PlusChar  = 8'h2b;
  localparam logic [7:0] SpaceChar = 8'h20;

  localparam int unsigned MaxResults = 3;

  localparam logic [2:0] AddrPlusAsSpace = 3'd0;

  typedef enum logic [1:0] {
    PhaseIdle  = 2'd0,
    PhasePct   = 2'd1,
    PhaseDigit = 2'd2,
    PhaseSpare = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } res_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      v = {1'b0, b[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

/* hw/rtl/upd_stream_if.sv */
// request channels of the url percent decoder: encoded characters in, decoded characters out
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink (input valid, out_byte, out_last, output ready);
endinterface

/* hw/rtl/url_percent_decoder.sv */
// url percent decoder top level: escape decoding, plus handling and result buffer
//
// Encoded characters arrive on in_i, one request per character, with in_last
// on the final character of a string. Decoded characters leave on out_o, with
// out_last on the final decoded character. "%hh" (either case) becomes one
// byte; with the plus-to-space bit set, '+' becomes a space; a broken or
// cut-off escape passes through literally.
// Each accepted character is decoded in the cycle it is taken and yields zero
// to three results, which sit in a three-entry result buffer and appear on
// out_o from the next cycle on.
// A new character is taken while the last buffered result is being delivered,
// so the block sustains one character per cycle whenever the receiver is ready and
// each character yields at most one result; one with more results holds the output
// until all are out. A stalled receiver holds the buffer and in turn input. The user
// writes the plus-to-space bit via APB port at address 0 only while idle; not enforced.
// Reset empties the buffer, clears any pending escape and clears the plus-to-space bit.
module url_percent_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  upd_in_if.sink      in_i,
  upd_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import upd_pkg::*;

  logic       plus_q;
  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  res_t       slot_q [MaxResults];
  res_t       slot_d [MaxResults];
  logic [1:0] rem_q, rem_d;

  logic       in_fire, out_fire;
  logic [7:0] b;
  logic       last;
  logic [4:0] v;
  logic [4:0] hi;

  logic       pfx_pct, pfx_held;
  logic       tail_vld;
  res_t       tail;
  logic       plain_run;
  res_t       res [MaxResults];
  logic [1:0] res_n;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrPlusAsSpace) ? {31'b0, plus_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == AddrPlusAsSpace) begin
      plus_q <= pwdata[0];
    end
  end

  assign in_i.ready   = (rem_q == 2'd0) || (rem_q == 2'd1 && out_o.ready);
  assign in_fire      = in_i.valid && in_i.ready;
  assign out_o.valid  = (rem_q != 2'd0);
  assign out_o.out_byte = slot_q[0].out_byte;
  assign out_o.out_last = slot_q[0].out_last;
  assign out_fire     = out_o.valid && out_o.ready;

  assign b    = in_i.in_byte;
  assign last = in_i.in_last;
  assign v    = hex_value(b);
  assign hi   = hex_value(held_q);

  // decode: optional literal prefix, then at most one tail result
  always_comb begin
    pfx_pct   = 1'b0;
    pfx_held  = 1'b0;
    plain_run = 1'b0;
    tail_vld  = 1'b0;
    tail      = '{out_byte: b, out_last: last};
    phase_d   = PhaseIdle;
    held_d    = held_q;
    case (phase_q)
      PhasePct: begin
        if (!v[4]) begin
          if (last) begin
            pfx_pct  = 1'b1;
            tail_vld = 1'b1;
          end else begin
            held_d  = b;
            phase_d = PhaseDigit;
          end
        end else begin
          pfx_pct   = 1'b1;
          plain_run = 1'b1;
        end
      end
      PhaseDigit: begin
        if (!v[4]) begin
          tail_vld = 1'b1;
          tail     = '{out_byte: {hi[3:0], v[3:0]}, out_last: last};
        end else begin
          pfx_pct   = 1'b1;
          pfx_held  = 1'b1;
          plain_run = 1'b1;
        end
      end
      default: begin
        plain_run = 1'b1;
      end
    endcase
    if (plain_run) begin
      if (b == PctChar && !last) begin
        phase_d = PhasePct;
      end else begin
        tail_vld = 1'b1;
        if (b == PlusChar && plus_q) begin
          tail.out_byte = SpaceChar;
        end
      end
    end
  end

  always_comb begin
    res[0] = '{out_byte: PctChar, out_last: 1'b0};
    res[1] = '{out_byte: held_q, out_last: 1'b0};
    res[2] = tail;
    res_n  = 2'd0;
    if (pfx_held) begin
      res_n = {1'b1, tail_vld};
    end else if (pfx_pct) begin
      res[1] = tail;
      res_n  = {tail_vld, ~tail_vld};
    end else begin
      res[0] = tail;
      res_n  = {1'b0, tail_vld};
    end
  end

  always_comb begin
    rem_d  = rem_q;
    slot_d = slot_q;
    if (in_fire) begin
      rem_d  = res_n;
      slot_d = res;
    end else if (out_fire) begin
      rem_d     = rem_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseIdle;
      held_q  <= 8'h00;
      rem_q   <= 2'd0;
    end else begin
      rem_q <= rem_d;
      if (in_fire) begin
        phase_q <= phase_d;
        held_q  <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
